// ===== rtl/etlu_pkg.sv =====
// Shared types and constants for the embedding table lookup/update engine.
// Holds table geometry, arithmetic widths, action codes, register indices and payload structs. No dependencies.
`default_nettype none
package etlu_pkg;

  localparam int TABLE_ROWS  = 1024;
  localparam int EMBED_DIM   = 64;
  localparam int STORE_DEPTH = TABLE_ROWS * EMBED_DIM;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  localparam int DATA_W = 16;
  localparam int FACT_W = 16;
  localparam int PROD_W = DATA_W + FACT_W + 1;
  localparam int FRAC_SHIFT = 14;
  localparam int SCALED_W = PROD_W - FRAC_SHIFT;
  localparam int SUM_W = SCALED_W + 1;

  localparam logic [2:0] ACT_LOOKUP     = 3'd0;
  localparam logic [2:0] ACT_ACCUM_GRAD = 3'd1;
  localparam logic [2:0] ACT_UPDATE_WT  = 3'd2;
  localparam logic [2:0] ACT_LOAD_WT    = 3'd3;
  localparam logic [2:0] ACT_READ_GRAD  = 3'd4;
  localparam logic [2:0] ACT_CLEAR_GRAD = 3'd5;

  localparam logic [7:0] REG_GRAD_SCALE    = 8'd0;
  localparam logic [7:0] REG_LEARNING_RATE = 8'd1;

  localparam logic [FACT_W-1:0] FACTOR_ONE = 16'd16384;

  typedef struct packed {
    logic [2:0]               action;
    logic [10:0]              row;
    logic [5:0]               column;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic                     bad_row;
  } out_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic                     weight_we;
    logic                     grad_we;
  } alu_res_t;

endpackage
`default_nettype wire

// ===== rtl/etlu_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
`default_nettype none
module etlu_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/etlu_alu.sv =====
// Element arithmetic: rounds factor*value to Q3.12, adds or subtracts, saturates,
// and picks the result and write enables per action. Depends on etlu_pkg.
`default_nettype none
module etlu_alu (
  input  wire logic [2:0]                             action,
  input  wire logic signed [etlu_pkg::DATA_W-1:0]     weight,
  input  wire logic signed [etlu_pkg::DATA_W-1:0]     grad,
  input  wire logic signed [etlu_pkg::DATA_W-1:0]     value,
  input  wire logic signed [etlu_pkg::PROD_W-1:0]     product,
  output etlu_pkg::alu_res_t                          res
);

  logic signed [etlu_pkg::PROD_W-1:0]   rounded;
  logic signed [etlu_pkg::SCALED_W-1:0] scaled;
  logic signed [etlu_pkg::SUM_W-1:0]    sum;
  logic signed [etlu_pkg::SUM_W-1:0]    base;
  logic signed [etlu_pkg::DATA_W-1:0]   sat;
  logic                                 subtract;

  localparam logic signed [etlu_pkg::SUM_W-1:0] MAX_V = etlu_pkg::SUM_W'(32767);
  localparam logic signed [etlu_pkg::SUM_W-1:0] MIN_V = -etlu_pkg::SUM_W'(32768);

  always_comb begin
    // add half an LSB, then arithmetic shift floors: ties go toward +inf
    rounded  = product + etlu_pkg::PROD_W'(8192);
    scaled   = etlu_pkg::SCALED_W'(rounded >>> etlu_pkg::FRAC_SHIFT);
    subtract = (action == etlu_pkg::ACT_UPDATE_WT);
    base     = subtract ? etlu_pkg::SUM_W'(weight) : etlu_pkg::SUM_W'(grad);
    if (subtract) begin
      sum = base - etlu_pkg::SUM_W'(scaled);
    end else begin
      sum = base + etlu_pkg::SUM_W'(scaled);
    end
    if (sum > MAX_V) begin
      sat = 16'sh7fff;
    end else if (sum < MIN_V) begin
      sat = -16'sh8000;
    end else begin
      sat = etlu_pkg::DATA_W'(sum);
    end

    res = '0;
    unique case (action)
      etlu_pkg::ACT_LOOKUP:     res.data = weight;
      etlu_pkg::ACT_ACCUM_GRAD: begin
        res.data    = sat;
        res.grad_we = 1'b1;
      end
      etlu_pkg::ACT_UPDATE_WT:  begin
        res.data      = sat;
        res.weight_we = 1'b1;
      end
      etlu_pkg::ACT_LOAD_WT:    begin
        res.data      = value;
        res.weight_we = 1'b1;
      end
      etlu_pkg::ACT_READ_GRAD:  res.data = grad;
      etlu_pkg::ACT_CLEAR_GRAD: res.grad_we = 1'b1;
      default:                  res.data = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/embedding_table_lookup_update.sv =====
// Top level of the embedding table engine: handshakes, sequencer, factor registers.
// Depends on etlu_pkg, etlu_ram (weight and gradient stores) and etlu_alu.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready  | in_item  (etlu_pkg::in_item_t)
//  out     | output    | out_valid/ out_ready | out_item (etlu_pkg::out_item_t)
//  cfg     | input     | cfg_valid/ cfg_ready | cfg_index, cfg_data
//
// Each item passes through accept (address decode), memory read with factor
// multiply, then write-back and result load, a read-modify-write through the
// registered-read stores. A result waiting on out_ready holds write-back; the
// next item is accepted while a finished result still waits. Reset idles the
// control and sets both factors to FACTOR_ONE; store contents stay undefined.
`default_nettype none
module embedding_table_lookup_update (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire etlu_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output etlu_pkg::out_item_t      out_item,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [7:0]          cfg_index,
  input  wire logic [15:0]         cfg_data
);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_WRITE} state_t;

  state_t                                state_r;
  etlu_pkg::in_item_t                    item_r;
  logic                                  bad_r;
  logic [etlu_pkg::ADDR_W-1:0]           addr_r;
  logic [etlu_pkg::ADDR_W-1:0]           addr_nxt;
  logic                                  bad_nxt;
  logic [etlu_pkg::FACT_W-1:0]           grad_scale_r;
  logic [etlu_pkg::FACT_W-1:0]           learning_rate_r;
  logic signed [etlu_pkg::PROD_W-1:0]    product_r;
  logic signed [etlu_pkg::PROD_W-1:0]    product_nxt;
  logic                                  out_valid_r;
  etlu_pkg::out_item_t                   out_item_r;
  logic [etlu_pkg::DATA_W-1:0]           weight_q;
  logic [etlu_pkg::DATA_W-1:0]           grad_q;
  etlu_pkg::alu_res_t                    alu_res;
  logic                                  in_xfer;
  logic                                  finish;
  logic                                  rd_en;
  logic [31:0]                           addr_full;
  logic [etlu_pkg::FACT_W-1:0]           factor;

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign rd_en     = (state_r == S_READ);
  assign finish    = (state_r == S_WRITE) && (!out_valid_r || out_ready);

  always_comb begin
    bad_nxt = (in_item.row == 11'd0) ||
              ({21'd0, in_item.row} > 32'(etlu_pkg::TABLE_ROWS)) ||
              ({26'd0, in_item.column} >= 32'(etlu_pkg::EMBED_DIM));
    addr_full = ({21'd0, in_item.row} - 32'd1) * 32'(etlu_pkg::EMBED_DIM) +
                {26'd0, in_item.column};
    addr_nxt  = addr_full[etlu_pkg::ADDR_W-1:0];
  end

  always_comb begin
    factor = (item_r.action == etlu_pkg::ACT_UPDATE_WT) ? learning_rate_r : grad_scale_r;
    product_nxt = $signed({1'b0, factor}) * item_r.value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grad_scale_r    <= etlu_pkg::FACTOR_ONE;
      learning_rate_r <= etlu_pkg::FACTOR_ONE;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == etlu_pkg::REG_GRAD_SCALE) begin
        grad_scale_r <= cfg_data;
      end else if (cfg_index == etlu_pkg::REG_LEARNING_RATE) begin
        learning_rate_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // a new result may load in the same cycle the old one transfers
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            state_r <= S_READ;
          end
        end
        S_READ: begin
          state_r <= S_WRITE;
        end
        S_WRITE: begin
          if (finish) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r <= in_item;
      bad_r  <= bad_nxt;
      addr_r <= addr_nxt;
    end
    if (rd_en) begin
      product_r <= product_nxt;
    end
    if (finish) begin
      out_item_r.data    <= bad_r ? '0 : alu_res.data;
      out_item_r.bad_row <= bad_r;
    end
  end

  etlu_alu u_alu (
    .action  (item_r.action),
    .weight  ($signed(weight_q)),
    .grad    ($signed(grad_q)),
    .value   (item_r.value),
    .product (product_r),
    .res     (alu_res)
  );

  etlu_ram #(
    .DEPTH (etlu_pkg::STORE_DEPTH),
    .WIDTH (etlu_pkg::DATA_W)
  ) u_weight_store (
    .clk   (clk),
    .we    (finish && !bad_r && alu_res.weight_we),
    .waddr (addr_r),
    .wdata (alu_res.data),
    .re    (rd_en),
    .raddr (addr_r),
    .rdata (weight_q)
  );

  etlu_ram #(
    .DEPTH (etlu_pkg::STORE_DEPTH),
    .WIDTH (etlu_pkg::DATA_W)
  ) u_grad_store (
    .clk   (clk),
    .we    (finish && !bad_r && alu_res.grad_we),
    .waddr (addr_r),
    .wdata (alu_res.data),
    .re    (rd_en),
    .raddr (addr_r),
    .rdata (grad_q)
  );

endmodule
`default_nettype wire

// ===== sim/embedding_table_lookup_update_test.sv =====
// Self-checking testbench for embedding_table_lookup_update: directed corner items, then
// random element traffic over a small hot set of table entries, under several factor settings.
// Depends on rtl/etlu_pkg.sv and the block's RTL.
module embedding_table_lookup_update_test;

  localparam logic [2:0] ACT_RSVD_LO = 3'd6;
  localparam logic [2:0] ACT_RSVD_HI = 3'd7;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 10;
  localparam int RANDOM_ITEMS = 1700;
  localparam int NUM_PHASES = 6;
  localparam int HOT_SET_MAX = 48;

  // Shadow copy of both stores and the factor registers; predicts one reply per request.
  class table_shadow;
    logic signed [etlu_pkg::DATA_W-1:0] wt_mem [etlu_pkg::STORE_DEPTH];
    logic signed [etlu_pkg::DATA_W-1:0] gr_mem [etlu_pkg::STORE_DEPTH];
    logic [etlu_pkg::FACT_W-1:0] grad_scale;
    logic [etlu_pkg::FACT_W-1:0] learn_rate;
    etlu_pkg::out_item_t pending_replies[$];
    int errors;

    function new();
      grad_scale = etlu_pkg::FACTOR_ONE;
      learn_rate = etlu_pkg::FACTOR_ONE;
      errors = 0;
    endfunction

    function void set_factor(logic [7:0] idx, logic [15:0] d);
      if (idx == etlu_pkg::REG_GRAD_SCALE) grad_scale = d;
      else if (idx == etlu_pkg::REG_LEARNING_RATE) learn_rate = d;
    endfunction

    // factor * v rounded half up to Q3.12, added to or taken from base, saturated once
    function logic signed [etlu_pkg::DATA_W-1:0] scaled_sum(
        logic signed [etlu_pkg::DATA_W-1:0] base,
        logic [etlu_pkg::FACT_W-1:0] factor,
        logic signed [etlu_pkg::DATA_W-1:0] v, bit subtract);
      longint prod;
      longint rnd;
      longint sum;
      prod = longint'(factor) * longint'(v);
      rnd = (prod + 64'sd8192) >>> etlu_pkg::FRAC_SHIFT;
      sum = subtract ? longint'(base) - rnd : longint'(base) + rnd;
      if (sum > 32767) return 16'sh7fff;
      if (sum < -32768) return 16'sh8000;
      return sum[etlu_pkg::DATA_W-1:0];
    endfunction

    function void apply_request(etlu_pkg::in_item_t it);
      int unsigned addr;
      etlu_pkg::out_item_t want;
      want.data = '0;
      want.bad_row = 1'b0;
      if (it.row < 1 || it.row > etlu_pkg::TABLE_ROWS || it.column >= etlu_pkg::EMBED_DIM) begin
        want.bad_row = 1'b1;
      end else begin
        addr = (int'(it.row) - 1) * etlu_pkg::EMBED_DIM + int'(it.column);
        case (it.action)
          etlu_pkg::ACT_LOOKUP: want.data = wt_mem[addr];
          etlu_pkg::ACT_ACCUM_GRAD: begin
            gr_mem[addr] = scaled_sum(gr_mem[addr], grad_scale, it.value, 1'b0);
            want.data = gr_mem[addr];
          end
          etlu_pkg::ACT_UPDATE_WT: begin
            wt_mem[addr] = scaled_sum(wt_mem[addr], learn_rate, it.value, 1'b1);
            want.data = wt_mem[addr];
          end
          etlu_pkg::ACT_LOAD_WT: begin
            wt_mem[addr] = it.value;
            want.data = it.value;
          end
          etlu_pkg::ACT_READ_GRAD: want.data = gr_mem[addr];
          etlu_pkg::ACT_CLEAR_GRAD: gr_mem[addr] = '0;
          default: ;
        endcase
      end
      pending_replies.push_back(want);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_reply(etlu_pkg::out_item_t got);
      etlu_pkg::out_item_t want;
      if (pending_replies.size() == 0) begin
        report($sformatf("unexpected reply data=%0d bad_row=%0b", got.data, got.bad_row));
      end else begin
        want = pending_replies.pop_front();
        if (got.data !== want.data)
          report($sformatf("data got %0d want %0d", got.data, want.data));
        if (got.bad_row !== want.bad_row)
          report($sformatf("bad_row got %0b want %0b", got.bad_row, want.bad_row));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  etlu_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  etlu_pkg::out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  table_shadow shadow = new();
  bit wt_written [etlu_pkg::STORE_DEPTH];
  bit gr_written [etlu_pkg::STORE_DEPTH];
  int hot_set[$];
  bit tx_calm;
  bit rx_calm;
  int rx_wait;
  int rx_stall;
  int cycle_count;

  embedding_table_lookup_update u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: check each transfer, then hold ready low for a random stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait <= 0;
    end else if (out_valid && out_ready) begin
      shadow.check_reply(out_item);
      rx_stall = rx_calm ? 0 : $urandom_range(0, 10);
      rx_wait <= rx_stall;
      out_ready <= (rx_stall == 0);
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      out_ready <= (rx_wait == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic etlu_pkg::in_item_t mk(logic [2:0] act, logic [10:0] row,
                                            logic [5:0] col, logic signed [15:0] v);
    etlu_pkg::in_item_t it;
    it.action = act;
    it.row = row;
    it.column = col;
    it.value = v;
    return it;
  endfunction

  // Random request over a hot set of entries; reads only ever hit entries written earlier.
  function automatic etlu_pkg::in_item_t next_request();
    int r;
    int a;
    int pick;
    logic [2:0] act;
    logic [10:0] row;
    logic signed [15:0] v;
    r = $urandom_range(0, 99);
    pick = $urandom_range(0, 4);
    case (pick)
      0: v = 16'sh8000;
      1: v = 16'sh7fff;
      2: v = -16'sd1;
      default: v = 16'($urandom_range(0, 65535));
    endcase
    if (hot_set.size() == 0 || $urandom_range(0, 99) < 15) begin
      a = $urandom_range(0, etlu_pkg::STORE_DEPTH - 1);
      if (hot_set.size() >= HOT_SET_MAX) hot_set[$urandom_range(0, HOT_SET_MAX - 1)] = a;
      else hot_set.push_back(a);
    end else begin
      a = hot_set[$urandom_range(0, hot_set.size() - 1)];
    end
    if (r < 6) begin
      row = $urandom_range(0, 1) ? 11'd0
                                 : 11'($urandom_range(etlu_pkg::TABLE_ROWS + 1, 2047));
      return mk(3'($urandom_range(0, 7)), row, 6'($urandom_range(0, 63)), v);
    end
    if (r < 9) begin
      act = $urandom_range(0, 1) ? ACT_RSVD_HI : ACT_RSVD_LO;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 15) act = etlu_pkg::ACT_LOOKUP;
      else if (pick < 40) act = etlu_pkg::ACT_ACCUM_GRAD;
      else if (pick < 65) act = etlu_pkg::ACT_UPDATE_WT;
      else if (pick < 75) act = etlu_pkg::ACT_LOAD_WT;
      else if (pick < 88) act = etlu_pkg::ACT_READ_GRAD;
      else act = etlu_pkg::ACT_CLEAR_GRAD;
      if ((act == etlu_pkg::ACT_LOOKUP || act == etlu_pkg::ACT_UPDATE_WT) && !wt_written[a])
        act = etlu_pkg::ACT_LOAD_WT;
      if ((act == etlu_pkg::ACT_ACCUM_GRAD || act == etlu_pkg::ACT_READ_GRAD) &&
          !gr_written[a])
        act = etlu_pkg::ACT_CLEAR_GRAD;
    end
    return mk(act, 11'(a / etlu_pkg::EMBED_DIM + 1), 6'(a % etlu_pkg::EMBED_DIM), v);
  endfunction

  task send_request(etlu_pkg::in_item_t it);
    int gap;
    int a;
    gap = tx_calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    shadow.apply_request(it);
    if (it.row >= 1 && it.row <= etlu_pkg::TABLE_ROWS) begin
      a = (int'(it.row) - 1) * etlu_pkg::EMBED_DIM + int'(it.column);
      if (it.action == etlu_pkg::ACT_LOAD_WT) wt_written[a] = 1'b1;
      if (it.action == etlu_pkg::ACT_CLEAR_GRAD) gr_written[a] = 1'b1;
    end
  endtask

  task write_reg(logic [7:0] idx, logic [15:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    shadow.set_factor(idx, d);
  endtask

  // Wait until every reply is in and the pipeline has settled.
  task wait_idle();
    in_valid <= 1'b0;
    while (shadow.pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task set_factors(logic [15:0] scale, logic [15:0] rate);
    write_reg(etlu_pkg::REG_GRAD_SCALE, scale);
    write_reg(etlu_pkg::REG_LEARNING_RATE, rate);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [15:0] scales [NUM_PHASES];
    logic [15:0] rates [NUM_PHASES];
    scales = '{16'd0, 16'd65535, 16'd16384, 16'd8192, 16'd0, 16'd0};
    rates = '{16'd0, 16'd65535, 16'd16384, 16'd49152, 16'd0, 16'd0};
    scales[4] = 16'($urandom_range(0, 65535));
    rates[4] = 16'($urandom_range(0, 65535));
    scales[5] = 16'($urandom_range(0, 65535));
    rates[5] = 16'($urandom_range(0, 65535));
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: max gradient scale for saturation, half learning rate for rounding ties.
    set_factors(16'd65535, 16'd8192);
    send_request(mk(etlu_pkg::ACT_LOAD_WT, 11'd1, 6'd0, 16'sh8000));
    send_request(mk(etlu_pkg::ACT_LOAD_WT, 11'd1024, 6'd63, 16'sh7fff));
    send_request(mk(etlu_pkg::ACT_LOOKUP, 11'd1, 6'd0, 16'sd0));
    send_request(mk(etlu_pkg::ACT_LOOKUP, 11'd1024, 6'd63, 16'sd0));
    send_request(mk(etlu_pkg::ACT_CLEAR_GRAD, 11'd1, 6'd0, 16'sh7fff));
    send_request(mk(etlu_pkg::ACT_CLEAR_GRAD, 11'd1024, 6'd63, 16'sd0));
    send_request(mk(etlu_pkg::ACT_ACCUM_GRAD, 11'd1, 6'd0, 16'sh7fff));
    send_request(mk(etlu_pkg::ACT_ACCUM_GRAD, 11'd1, 6'd0, 16'sh8000));
    send_request(mk(etlu_pkg::ACT_READ_GRAD, 11'd1, 6'd0, 16'sd0));
    send_request(mk(etlu_pkg::ACT_UPDATE_WT, 11'd1024, 6'd63, 16'sh8000));
    send_request(mk(etlu_pkg::ACT_UPDATE_WT, 11'd1, 6'd0, 16'sh7fff));
    send_request(mk(etlu_pkg::ACT_LOAD_WT, 11'd512, 6'd21, 16'sd0));
    send_request(mk(etlu_pkg::ACT_UPDATE_WT, 11'd512, 6'd21, 16'sd1));
    send_request(mk(etlu_pkg::ACT_UPDATE_WT, 11'd512, 6'd21, -16'sd1));
    send_request(mk(etlu_pkg::ACT_UPDATE_WT, 11'd512, 6'd21, 16'sd3));
    send_request(mk(etlu_pkg::ACT_CLEAR_GRAD, 11'd512, 6'd21, 16'sd0));
    send_request(mk(etlu_pkg::ACT_ACCUM_GRAD, 11'd512, 6'd21, -16'sd1));
    send_request(mk(etlu_pkg::ACT_LOOKUP, 11'd0, 6'd0, 16'sd0));
    send_request(mk(etlu_pkg::ACT_ACCUM_GRAD, 11'd1025, 6'd5, 16'sd100));
    send_request(mk(etlu_pkg::ACT_LOAD_WT, 11'd2047, 6'd63, 16'sh7fff));
    send_request(mk(ACT_RSVD_LO, 11'd1, 6'd0, 16'sh7fff));
    send_request(mk(ACT_RSVD_HI, 11'd1024, 6'd63, 16'sh8000));
    send_request(mk(etlu_pkg::ACT_READ_GRAD, 11'd1024, 6'd63, 16'sd0));
    send_request(mk(etlu_pkg::ACT_LOOKUP, 11'd512, 6'd21, 16'sd0));

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      set_factors(scales[p], rates[p]);
      for (int i = 0; i < RANDOM_ITEMS / NUM_PHASES; i++) begin
        // switch between idling and back-to-back stretches now and then
        if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
        if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
        send_request(next_request());
      end
    end
    wait_idle();

    if (shadow.errors == 0 && shadow.pending_replies.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
